// ===== rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg: shared constants for the Barrett modular ALU
// Opcodes, status codes, field widths and default parameter values.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int unsigned MOD_WIDTH_DEF = 32;
  localparam int unsigned EXP_WIDTH_DEF = 64;
  localparam int unsigned RED_W         = 64;   // raw operand width
  localparam int unsigned RES_W         = 32;   // result / modulus field width
  localparam int unsigned ST_W          = 2;
  localparam int unsigned OPC_W         = 4;

  localparam logic [RES_W-1:0] MOD_RESET = 32'd1000000007;

  localparam logic [OPC_W-1:0] OP_REDU = 4'd0;
  localparam logic [OPC_W-1:0] OP_REDS = 4'd1;
  localparam logic [OPC_W-1:0] OP_ADD  = 4'd2;
  localparam logic [OPC_W-1:0] OP_SUB  = 4'd3;
  localparam logic [OPC_W-1:0] OP_NEG  = 4'd4;
  localparam logic [OPC_W-1:0] OP_MUL  = 4'd5;
  localparam logic [OPC_W-1:0] OP_DIV  = 4'd6;
  localparam logic [OPC_W-1:0] OP_POW  = 4'd7;
  localparam logic [OPC_W-1:0] OP_INV  = 4'd8;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO   = 2'd1;
  localparam logic [ST_W-1:0] ST_NCOPR  = 2'd2;

endpackage

// ===== rtl/bma_in_if.sv =====
// ----------------------------------------------------------------------------
// bma_in_if: request channel
// Opcode and two raw operands with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bma_in_if;
  import bma_pkg::*;
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [RED_W-1:0] operand_a;
  logic [RED_W-1:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

// ===== rtl/bma_out_if.sv =====
// ----------------------------------------------------------------------------
// bma_out_if: result channel
// Reduced result and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bma_out_if;
  import bma_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  logic [ST_W-1:0]  status;
  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

// ===== rtl/barrett_modular_alu_top.sv =====
// ----------------------------------------------------------------------------
// barrett_modular_alu_top: modular arithmetic unit
// Bit-serial reduce, add, sub, neg, mul, div, pow and inverse modulo m.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_i.ready is high only while the unit is
// idle, and the result is held on out_o until taken. The datapath is
// bit-serial, one bit per cycle: every item first reduces operand_a, and all
// but pow also operand_b. Add, sub, neg and the reduces then finish in the
// dispatch state; mul adds one modular multiply; pow takes up to 2*EXP_WIDTH
// modular multiplies, plus loop overhead per exponent bit; inverse runs one
// Euclid step per quotient, each a MOD_WIDTH-bit division plus a modular
// multiply, and div adds one multiply after it. A modulus below two or an
// unused opcode gives 0 after the operand reduces. The modulus register is
// written through cfg_we_i and cfg_data_i; the user must write it only while
// no item is in flight, as the block does not enforce this. Bits above
// MOD_WIDTH are dropped.
module barrett_modular_alu_top #(
  parameter int unsigned MOD_WIDTH = bma_pkg::MOD_WIDTH_DEF,
  parameter int unsigned EXP_WIDTH = bma_pkg::EXP_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bma_pkg::RES_W-1:0] cfg_data_i,
  bma_in_if.sink                    in_i,
  bma_out_if.source                 out_o
);
  import bma_pkg::*;

  localparam int unsigned W     = MOD_WIDTH;
  localparam int unsigned CNT_W = $clog2(RED_W + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_REDA = 13'b0000000000010,  // serial reduce of operand a
    S_REDB = 13'b0000000000100,  // serial reduce of operand b
    S_DISP = 13'b0000000001000,  // per-opcode dispatch
    S_MUL  = 13'b0000000010000,  // shared serial modular multiplier
    S_EUC  = 13'b0000000100000,  // Euclid loop head
    S_QDIV = 13'b0000001000000,  // restoring division g / h
    S_EUPD = 13'b0000010000000,  // Euclid coefficient update
    S_POW  = 13'b0000100000000,  // exponent loop head
    S_POWM = 13'b0001000000000,  // product taken into accumulator
    S_POWS = 13'b0010000000000,  // square taken into base
    S_FIN  = 13'b0100000000000,  // final product is the result
    S_DONE = 13'b1000000000000
  } state_e;

  state_e               state_q, state_d, mret_q, mret_d;
  logic [W-1:0]         mod_q;
  logic [OPC_W-1:0]     op_q, op_d;
  logic [RED_W-1:0]     sa_q, sa_d, b_q, b_d;
  logic [EXP_WIDTH-1:0] e_q, e_d;
  logic [W-1:0]         ra_q, ra_d, rb_q, rb_d;
  logic [W-1:0]         g_q, g_d, h_q, h_d, x_q, x_d, y_q, y_d;
  logic [W:0]           rem_q, rem_d;
  logic [W-1:0]         qsh_q, qsh_d;
  logic [W-1:0]         ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [W-1:0]         base_q, base_d, pacc_q, pacc_d;
  logic [W-1:0]         res_q, res_d;
  logic [ST_W-1:0]      st_q, st_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 neg_q, neg_d;

  logic [W:0]   mx, red_t, red_n, m2, m2r, m3, m3r, div_t, sum_t, dif_t;
  logic [W-1:0] red_acc, inv_v;
  logic         last;

  assign mx   = {1'b0, mod_q};
  assign last = (cnt_q == CNT_W'(1));

  always_comb begin
    // one bit of the raw operand shifted into the running remainder
    red_acc = (state_q == S_REDB) ? rb_q : ra_q;
    red_t   = {red_acc, sa_q[RED_W-1]};
    red_n   = (red_t >= mx) ? red_t - mx : red_t;
    // multiplier step: acc = 2*acc (+ a) mod m, multiplier MSB first
    m2      = {acc_q, 1'b0};
    m2r     = (m2 >= mx) ? m2 - mx : m2;
    m3      = mb_q[W-1] ? m2r + {1'b0, ma_q} : m2r;
    m3r     = (m3 >= mx) ? m3 - mx : m3;
    // restoring division step
    div_t   = {rem_q[W-1:0], qsh_q[W-1]};
    sum_t   = {1'b0, ra_q} + {1'b0, rb_q};
    dif_t   = {1'b0, x_q} - {1'b0, acc_q};
    inv_v   = (op_q == OP_DIV) ? rb_q : ra_q;
  end

  always_comb begin
    state_d = state_q;  mret_d = mret_q;  op_d = op_q;
    sa_d = sa_q;  b_d = b_q;  e_d = e_q;  ra_d = ra_q;  rb_d = rb_q;
    g_d = g_q;  h_d = h_q;  x_d = x_q;  y_d = y_q;
    rem_d = rem_q;  qsh_d = qsh_q;
    ma_d = ma_q;  mb_d = mb_q;  acc_d = acc_q;
    base_d = base_q;  pacc_d = pacc_q;
    res_d = res_q;  st_d = st_q;  cnt_d = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d  = in_i.opcode;
          // reduce_s of a negative value works on its magnitude
          sa_d  = (in_i.opcode == OP_REDS && in_i.operand_a[RED_W-1])
                  ? RED_W'(0) - in_i.operand_a : in_i.operand_a;
          b_d   = in_i.operand_b;
          e_d   = in_i.operand_b[EXP_WIDTH-1:0];
          ra_d  = '0;
          rb_d  = '0;
          res_d = '0;
          st_d  = ST_OK;
          cnt_d = CNT_W'(RED_W);
          state_d = S_REDA;
        end
      end
      S_REDA: begin
        ra_d  = red_n[W-1:0];
        sa_d  = {sa_q[RED_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (last) begin
          sa_d  = b_q;
          cnt_d = CNT_W'(RED_W);
          state_d = (op_q == OP_POW) ? S_DISP : S_REDB;
        end
      end
      S_REDB: begin
        rb_d  = red_n[W-1:0];
        sa_d  = {sa_q[RED_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (last) state_d = S_DISP;
      end
      S_DISP: begin
        state_d = S_DONE;
        ma_d  = ra_q;
        mb_d  = rb_q;
        acc_d = '0;
        cnt_d = CNT_W'(W);
        if (mod_q >= W'(2)) begin
          unique case (op_q)
            OP_REDU: res_d = ra_q;
            // negative value: fold the magnitude's remainder back, zero stays zero
            OP_REDS: res_d = (neg_q && ra_q != '0) ? mod_q - ra_q : ra_q;
            OP_ADD:  res_d = (sum_t >= mx) ? W'(sum_t - mx) : W'(sum_t);
            OP_SUB:  res_d = (ra_q >= rb_q) ? ra_q - rb_q : ra_q - rb_q + mod_q;
            OP_NEG:  res_d = (ra_q == '0) ? '0 : mod_q - ra_q;
            OP_MUL: begin
              mret_d  = S_FIN;
              state_d = S_MUL;
            end
            OP_DIV, OP_INV: begin
              if (inv_v == '0) begin
                st_d = ST_ZERO;
              end else begin
                g_d = mod_q;
                h_d = inv_v;
                x_d = '0;
                y_d = W'(1);
                state_d = S_EUC;
              end
            end
            OP_POW: begin
              pacc_d  = W'(1);
              base_d  = ra_q;
              state_d = S_POW;
            end
            default: res_d = '0;
          endcase
        end
      end
      S_MUL: begin
        acc_d = m3r[W-1:0];
        mb_d  = {mb_q[W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (last) state_d = mret_q;
      end
      S_EUC: begin
        if (h_q == '0) begin
          if (g_q != W'(1)) begin
            st_d = ST_NCOPR;
            state_d = S_DONE;
          end else if (op_q == OP_DIV) begin
            ma_d  = ra_q;
            mb_d  = x_q;
            acc_d = '0;
            cnt_d = CNT_W'(W);
            mret_d  = S_FIN;
            state_d = S_MUL;
          end else begin
            res_d = x_q;
            state_d = S_DONE;
          end
        end else begin
          rem_d = '0;
          qsh_d = g_q;
          cnt_d = CNT_W'(W);
          state_d = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_t >= {1'b0, h_q}) begin
          rem_d = div_t - {1'b0, h_q};
          qsh_d = {qsh_q[W-2:0], 1'b1};
        end else begin
          rem_d = div_t;
          qsh_d = {qsh_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (last) begin
          // quotient times y, modulo m
          ma_d  = y_q;
          mb_d  = qsh_d;
          acc_d = '0;
          cnt_d = CNT_W'(W);
          mret_d  = S_EUPD;
          state_d = S_MUL;
        end
      end
      S_EUPD: begin
        g_d = h_q;
        h_d = rem_q[W-1:0];
        x_d = y_q;
        y_d = dif_t[W] ? W'(dif_t + mx) : W'(dif_t);
        state_d = S_EUC;
      end
      S_POW: begin
        acc_d = '0;
        cnt_d = CNT_W'(W);
        if (e_q == '0) begin
          res_d = pacc_q;
          state_d = S_DONE;
        end else if (e_q[0]) begin
          ma_d = pacc_q;
          mb_d = base_q;
          mret_d  = S_POWM;
          state_d = S_MUL;
        end else begin
          ma_d = base_q;
          mb_d = base_q;
          mret_d  = S_POWS;
          state_d = S_MUL;
        end
      end
      S_POWM: begin
        pacc_d = acc_q;
        ma_d   = base_q;
        mb_d   = base_q;
        acc_d  = '0;
        cnt_d  = CNT_W'(W);
        mret_d  = S_POWS;
        state_d = S_MUL;
      end
      S_POWS: begin
        base_d  = acc_q;
        e_d     = e_q >> 1;
        state_d = S_POW;
      end
      S_FIN: begin
        res_d = acc_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sign of a reduce_s operand, kept for the final fold
  assign neg_d = (state_q == S_IDLE) ? in_i.operand_a[RED_W-1] : neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mret_q  <= S_FIN;
      mod_q   <= MOD_RESET[W-1:0];
    end else begin
      state_q <= state_d;
      mret_q  <= mret_d;
      if (cfg_we_i) mod_q <= cfg_data_i[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  neg_q <= neg_d;
    sa_q <= sa_d;  b_q <= b_d;  e_q <= e_d;  ra_q <= ra_d;  rb_q <= rb_d;
    g_q <= g_d;  h_q <= h_d;  x_q <= x_d;  y_q <= y_d;
    rem_q <= rem_d;  qsh_q <= qsh_d;
    ma_q <= ma_d;  mb_q <= mb_d;  acc_q <= acc_d;
    base_q <= base_d;  pacc_q <= pacc_d;
    res_q <= res_d;  st_q <= st_d;  cnt_q <= cnt_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = (state_q == S_DONE);
  assign out_o.result = RES_W'(res_q);
  assign out_o.status = st_q;

  // assertions
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_res_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && mod_q >= W'(2)) |-> (res_q < mod_q))
    else $error("result not reduced");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && st_q != ST_OK) |-> (res_q == '0))
    else $error("error status with nonzero result");
  a_mul_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (acc_q < mod_q))
    else $error("multiplier accumulator out of range");

endmodule
